@@ hdl/z80af_pkg.sv @@
package z80af_pkg;

  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_ADC    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_SBC    = 5'd3;
  localparam logic [4:0] OP_AND    = 5'd4;
  localparam logic [4:0] OP_XOR    = 5'd5;
  localparam logic [4:0] OP_OR     = 5'd6;
  localparam logic [4:0] OP_CP     = 5'd7;
  localparam logic [4:0] OP_ADD16  = 5'd8;
  localparam logic [4:0] OP_ADC16  = 5'd9;
  localparam logic [4:0] OP_SBC16  = 5'd10;
  localparam logic [4:0] OP_SHIFT  = 5'd11;
  localparam logic [4:0] OP_BIT    = 5'd12;
  localparam logic [4:0] OP_RES    = 5'd13;
  localparam logic [4:0] OP_SET    = 5'd14;
  localparam logic [4:0] OP_BLKCMP = 5'd15;
  localparam logic [4:0] OP_BLKLD  = 5'd16;

  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_PASS = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  localparam logic [2:0] BIT_SIGN = 3'd7;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [7:0]  acc;
    logic [7:0]  flags_in;
    logic [7:0]  operand8;
    logic [15:0] hl_in;
    logic [15:0] operand16;
    logic [2:0]  bit_sel;
    logic [15:0] remaining_count;
  } alu_req_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_pair;
    logic [7:0]  flags_out;
  } alu_rsp_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  acc;
    logic [7:0]  fin;
    logic [7:0]  opnd;
    logic [15:0] hl;
    logic [2:0]  sel;
    logic        bc_nz;
    logic [7:0]  ar8;
    logic        ac8;
    logic        ah8;
    logic        av8;
    logic [15:0] ar16;
    logic        ac16;
    logic        ah16;
    logic        av16;
    logic [7:0]  lr8;
    logic        lco;
    logic        bit_t;
  } alu_mid_t;

endpackage

@@ hdl/z80_alu_flag_unit.sv @@
// Z80-style ALU and flag unit with three register stages: the request is
// registered, then the 8- and 16-bit adders, logic and shift results are
// formed, then flags are assembled into the output register. For every
// operation the response waits in the output register, rsp_valid high,
// until rsp_ready is high. A new request can be accepted every cycle; a
// stalled output backs up the pipeline one stage at a time, so req_ready
// stays high while any stage is empty. The block holds no state between
// transactions.
module z80_alu_flag_unit
  import z80af_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  alu_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output alu_rsp_t rsp
);

  logic     v1, v2, v3;
  logic     adv1, adv2, adv3;
  alu_req_t s1;
  alu_mid_t s2, s2_next;
  alu_rsp_t s3, s3_next;

  assign adv3      = !v3 || rsp_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req_ready = adv1;
  assign rsp_valid = v3;
  assign rsp       = s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= req_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= req;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
  end

  // stage 2: adders, logic and shifts
  always_comb begin
    logic       cin, c8, c16, sub8;
    logic [8:0] r9;
    logic [4:0] n5;
    logic [16:0] r17;
    logic [12:0] n13;
    logic [7:0] v;

    cin  = s1.flags_in[0];
    v    = s1.operand8;
    sub8 = s1.req_type inside {OP_SUB, OP_SBC, OP_CP, OP_BLKCMP};
    c8   = (s1.req_type inside {OP_ADC, OP_SBC}) ? cin : 1'b0;
    c16  = (s1.req_type inside {OP_ADC16, OP_SBC16}) ? cin : 1'b0;

    s2_next.op    = s1.req_type;
    s2_next.acc   = s1.acc;
    s2_next.fin   = s1.flags_in;
    s2_next.opnd  = v;
    s2_next.hl    = s1.hl_in;
    s2_next.sel   = s1.bit_sel;
    s2_next.bc_nz = |s1.remaining_count;
    s2_next.bit_t = v[s1.bit_sel];

    if (sub8) begin
      r9 = {1'b0, s1.acc} - {1'b0, v} - {8'd0, c8};
      n5 = {1'b0, s1.acc[3:0]} - {1'b0, v[3:0]} - {4'd0, c8};
      s2_next.av8 = (s1.acc[7] ^ v[7]) & (s1.acc[7] ^ r9[7]);
    end else begin
      r9 = {1'b0, s1.acc} + {1'b0, v} + {8'd0, c8};
      n5 = {1'b0, s1.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, c8};
      s2_next.av8 = (s1.acc[7] ^ r9[7]) & (v[7] ^ r9[7]);
    end
    s2_next.ar8 = r9[7:0];
    s2_next.ac8 = r9[8];
    s2_next.ah8 = n5[4];

    if (s1.req_type == OP_SBC16) begin
      r17 = {1'b0, s1.hl_in} - {1'b0, s1.operand16} - {16'd0, c16};
      n13 = {1'b0, s1.hl_in[11:0]} - {1'b0, s1.operand16[11:0]} - {12'd0, c16};
      s2_next.av16 = (s1.hl_in[15] ^ s1.operand16[15]) & (s1.hl_in[15] ^ r17[15]);
    end else begin
      r17 = {1'b0, s1.hl_in} + {1'b0, s1.operand16} + {16'd0, c16};
      n13 = {1'b0, s1.hl_in[11:0]} + {1'b0, s1.operand16[11:0]} + {12'd0, c16};
      s2_next.av16 = (s1.hl_in[15] ^ r17[15]) & (s1.operand16[15] ^ r17[15]);
    end
    s2_next.ar16 = r17[15:0];
    s2_next.ac16 = r17[16];
    s2_next.ah16 = n13[12];

    s2_next.lco = 1'b0;
    case (s1.bit_sel)
      SH_RLC:  s2_next.lco = v[7];
      SH_RL:   s2_next.lco = v[7];
      SH_SLA:  s2_next.lco = v[7];
      SH_RRC:  s2_next.lco = v[0];
      SH_RR:   s2_next.lco = v[0];
      SH_SRA:  s2_next.lco = v[0];
      SH_SRL:  s2_next.lco = v[0];
      default: s2_next.lco = 1'b0;
    endcase

    case (s1.req_type)
      OP_AND: s2_next.lr8 = s1.acc & v;
      OP_XOR: s2_next.lr8 = s1.acc ^ v;
      OP_OR:  s2_next.lr8 = s1.acc | v;
      OP_RES: s2_next.lr8 = v & ~(8'd1 << s1.bit_sel);
      OP_SET: s2_next.lr8 = v | (8'd1 << s1.bit_sel);
      OP_SHIFT: begin
        case (s1.bit_sel)
          SH_RLC:  s2_next.lr8 = {v[6:0], v[7]};
          SH_RRC:  s2_next.lr8 = {v[0], v[7:1]};
          SH_RL:   s2_next.lr8 = {v[6:0], cin};
          SH_RR:   s2_next.lr8 = {cin, v[7:1]};
          SH_SLA:  s2_next.lr8 = {v[6:0], 1'b0};
          SH_SRA:  s2_next.lr8 = {v[7], v[7:1]};
          SH_SRL:  s2_next.lr8 = {1'b0, v[7:1]};
          default: s2_next.lr8 = v;
        endcase
      end
      default: s2_next.lr8 = v;
    endcase
  end

  // stage 3: flag assembly and result select
  always_comb begin
    logic       z8, zl, z16, par;
    logic [7:0] u;

    z8  = (s2.ar8 == 8'd0);
    zl  = (s2.lr8 == 8'd0);
    z16 = (s2.ar16 == 16'd0);
    par = ~(^s2.lr8);
    u   = s2.ar8 - {7'd0, s2.ah8};

    s3_next.result_byte = s2.acc;
    s3_next.result_pair = s2.hl;
    s3_next.flags_out   = s2.fin;

    case (s2.op)
      OP_ADD, OP_ADC: begin
        s3_next.result_byte = s2.ar8;
        s3_next.flags_out   = {s2.ar8[7], z8, s2.ar8[5], s2.ah8, s2.ar8[3],
                               s2.av8, 1'b0, s2.ac8};
      end
      OP_SUB, OP_SBC: begin
        s3_next.result_byte = s2.ar8;
        s3_next.flags_out   = {s2.ar8[7], z8, s2.ar8[5], s2.ah8, s2.ar8[3],
                               s2.av8, 1'b1, s2.ac8};
      end
      OP_CP: begin
        s3_next.flags_out = {s2.ar8[7], z8, s2.ar8[5], s2.ah8, s2.ar8[3],
                             s2.av8, 1'b1, s2.ac8};
      end
      OP_AND: begin
        s3_next.result_byte = s2.lr8;
        s3_next.flags_out   = {s2.lr8[7], zl, s2.lr8[5], 1'b1, s2.lr8[3], par, 2'b00};
      end
      OP_XOR, OP_OR: begin
        s3_next.result_byte = s2.lr8;
        s3_next.flags_out   = {s2.lr8[7], zl, s2.lr8[5], 1'b0, s2.lr8[3], par, 2'b00};
      end
      OP_ADD16: begin
        s3_next.result_pair = s2.ar16;
        s3_next.flags_out   = {s2.fin[7], s2.fin[6], s2.ar16[13], s2.ah16, s2.ar16[11],
                               s2.fin[2], 1'b0, s2.ac16};
      end
      OP_ADC16: begin
        s3_next.result_pair = s2.ar16;
        s3_next.flags_out   = {s2.ar16[15], z16, s2.ar16[13], s2.ah16, s2.ar16[11],
                               s2.av16, 1'b0, s2.ac16};
      end
      OP_SBC16: begin
        s3_next.result_pair = s2.ar16;
        s3_next.flags_out   = {s2.ar16[15], z16, s2.ar16[13], s2.ah16, s2.ar16[11],
                               s2.av16, 1'b1, s2.ac16};
      end
      OP_SHIFT: begin
        s3_next.result_byte = s2.lr8;
        s3_next.flags_out   = {s2.lr8[7], zl, s2.lr8[5], 1'b0, s2.lr8[3], par,
                               1'b0, s2.lco};
      end
      OP_BIT: begin
        s3_next.flags_out = {(s2.sel == BIT_SIGN) && s2.bit_t, !s2.bit_t, s2.opnd[5],
                             1'b1, s2.opnd[3], 2'b00, s2.fin[0]};
      end
      OP_RES, OP_SET: begin
        s3_next.result_byte = s2.lr8;
      end
      OP_BLKCMP: begin
        s3_next.flags_out = {s2.ar8[7], z8, u[3], s2.ah8, u[1], s2.bc_nz,
                             1'b1, s2.fin[0]};
      end
      OP_BLKLD: begin
        s3_next.flags_out = {s2.fin[7], s2.fin[6], 3'b000, s2.bc_nz, 1'b0, s2.fin[0]};
      end
      default: begin
        s3_next.flags_out = s2.fin;
      end
    endcase
  end

  // a stalled middle stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv2) |=> (v2 && $stable(s2)))
    else $error("stage 2 item changed while stalled");

  // an item leaving stage 1 arrives in stage 2
  assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2) |=> v2)
    else $error("item lost between stage 1 and stage 2");

  // ready only with room somewhere in the pipeline
  assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (!v1 || !v2 || !v3 || rsp_ready))
    else $error("request taken with a full, stalled pipeline");

endmodule

@@ tb/z80_alu_flag_unit_tb.sv @@
`timescale 1ns / 100ps

module z80_alu_flag_unit_tb
  import z80af_pkg::*;
();

  localparam logic [7:0] F_S = 8'h80;
  localparam logic [7:0] F_Z = 8'h40;
  localparam logic [7:0] F_Y = 8'h20;
  localparam logic [7:0] F_H = 8'h10;
  localparam logic [7:0] F_X = 8'h08;
  localparam logic [7:0] F_V = 8'h04;
  localparam logic [7:0] F_N = 8'h02;
  localparam logic [7:0] F_C = 8'h01;

  localparam logic [4:0] OP_UNUSED_LO = 5'd17;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;
  localparam int NUM_OPS = 17;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    alu_req_t req;
    alu_rsp_t rsp;
  } alu_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  alu_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  alu_rsp_t rsp;

  alu_expect_t pending_results[$];
  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int op_seen[32];
  int src_gap_max = 5;
  int sink_stall_max = 5;
  int idle_cycles = 0;

  logic [4:0] all_ops[NUM_OPS] = '{OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR,
                                   OP_CP, OP_ADD16, OP_ADC16, OP_SBC16, OP_SHIFT, OP_BIT,
                                   OP_RES, OP_SET, OP_BLKCMP, OP_BLKLD};

  z80_alu_flag_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // flag helpers
  function automatic logic [7:0] szyx8(logic [7:0] r);
    logic [7:0] f;
    f = r & (F_S | F_Y | F_X);
    if (r == 8'h00) f = f | F_Z;
    return f;
  endfunction

  function automatic logic [7:0] szyx16(logic [15:0] r);
    logic [7:0] f;
    f = 8'h00;
    if (r[15]) f = f | F_S;
    if (r == 16'h0000) f = f | F_Z;
    if (r[13]) f = f | F_Y;
    if (r[11]) f = f | F_X;
    return f;
  endfunction

  function automatic logic [7:0] parity8(logic [7:0] r);
    return (^r) ? 8'h00 : F_V;
  endfunction

  function automatic logic [15:0] add8_flags(logic [7:0] a, logic [7:0] v, logic c);
    logic [8:0] s;
    logic [4:0] h;
    logic [7:0] f;
    s = {1'b0, a} + {1'b0, v} + {8'h00, c};
    h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
    f = szyx8(s[7:0]);
    if (h[4]) f = f | F_H;
    if ((a[7] ^ s[7]) & (v[7] ^ s[7])) f = f | F_V;
    if (s[8]) f = f | F_C;
    return {s[7:0], f};
  endfunction

  function automatic logic [15:0] sub8_flags(logic [7:0] a, logic [7:0] v, logic c);
    logic [8:0] s;
    logic [4:0] h;
    logic [7:0] f;
    s = {1'b0, a} - {1'b0, v} - {8'h00, c};
    h = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, c};
    f = szyx8(s[7:0]) | F_N;
    if (h[4]) f = f | F_H;
    if ((a[7] ^ v[7]) & (a[7] ^ s[7])) f = f | F_V;
    if (s[8]) f = f | F_C;
    return {s[7:0], f};
  endfunction

  function automatic alu_rsp_t alu_predict(alu_req_t q);
    alu_rsp_t o;
    logic cin, co, t, hb;
    logic [7:0] v, r, d, u;
    logic [16:0] s17;
    logic [12:0] h13;
    logic [15:0] pair;
    cin = q.flags_in[0];
    v = q.operand8;
    o.result_byte = q.acc;
    o.result_pair = q.hl_in;
    o.flags_out = q.flags_in;
    case (q.req_type)
      OP_ADD, OP_ADC: begin
        pair = add8_flags(q.acc, v, (q.req_type == OP_ADC) ? cin : 1'b0);
        {o.result_byte, o.flags_out} = pair;
      end
      OP_SUB, OP_SBC: begin
        pair = sub8_flags(q.acc, v, (q.req_type == OP_SBC) ? cin : 1'b0);
        {o.result_byte, o.flags_out} = pair;
      end
      OP_CP: begin
        pair = sub8_flags(q.acc, v, 1'b0);
        o.flags_out = pair[7:0];
      end
      OP_AND: begin
        r = q.acc & v;
        o.result_byte = r;
        o.flags_out = szyx8(r) | parity8(r) | F_H;
      end
      OP_XOR: begin
        r = q.acc ^ v;
        o.result_byte = r;
        o.flags_out = szyx8(r) | parity8(r);
      end
      OP_OR: begin
        r = q.acc | v;
        o.result_byte = r;
        o.flags_out = szyx8(r) | parity8(r);
      end
      OP_ADD16: begin
        s17 = {1'b0, q.hl_in} + {1'b0, q.operand16};
        h13 = {1'b0, q.hl_in[11:0]} + {1'b0, q.operand16[11:0]};
        o.result_pair = s17[15:0];
        o.flags_out = q.flags_in & (F_S | F_Z | F_V);
        if (h13[12]) o.flags_out = o.flags_out | F_H;
        if (s17[13]) o.flags_out = o.flags_out | F_Y;
        if (s17[11]) o.flags_out = o.flags_out | F_X;
        if (s17[16]) o.flags_out = o.flags_out | F_C;
      end
      OP_ADC16: begin
        s17 = {1'b0, q.hl_in} + {1'b0, q.operand16} + {16'h0000, cin};
        h13 = {1'b0, q.hl_in[11:0]} + {1'b0, q.operand16[11:0]} + {12'h000, cin};
        o.result_pair = s17[15:0];
        o.flags_out = szyx16(s17[15:0]);
        if (h13[12]) o.flags_out = o.flags_out | F_H;
        if ((q.hl_in[15] ^ s17[15]) & (q.operand16[15] ^ s17[15]))
          o.flags_out = o.flags_out | F_V;
        if (s17[16]) o.flags_out = o.flags_out | F_C;
      end
      OP_SBC16: begin
        s17 = {1'b0, q.hl_in} - {1'b0, q.operand16} - {16'h0000, cin};
        h13 = {1'b0, q.hl_in[11:0]} - {1'b0, q.operand16[11:0]} - {12'h000, cin};
        o.result_pair = s17[15:0];
        o.flags_out = szyx16(s17[15:0]) | F_N;
        if (h13[12]) o.flags_out = o.flags_out | F_H;
        if ((q.hl_in[15] ^ q.operand16[15]) & (q.hl_in[15] ^ s17[15]))
          o.flags_out = o.flags_out | F_V;
        if (s17[16]) o.flags_out = o.flags_out | F_C;
      end
      OP_SHIFT: begin
        co = 1'b0;
        case (q.bit_sel)
          SH_RLC: begin co = v[7]; r = {v[6:0], v[7]}; end
          SH_RRC: begin co = v[0]; r = {v[0], v[7:1]}; end
          SH_RL:  begin co = v[7]; r = {v[6:0], cin}; end
          SH_RR:  begin co = v[0]; r = {cin, v[7:1]}; end
          SH_SLA: begin co = v[7]; r = {v[6:0], 1'b0}; end
          SH_SRA: begin co = v[0]; r = {v[7], v[7:1]}; end
          SH_SRL: begin co = v[0]; r = {1'b0, v[7:1]}; end
          default: r = v;
        endcase
        o.result_byte = r;
        o.flags_out = szyx8(r) | parity8(r) | {7'b0, co};
      end
      OP_BIT: begin
        t = v[q.bit_sel];
        o.flags_out = (q.flags_in & F_C) | F_H | (v & (F_Y | F_X));
        if (!t) o.flags_out = o.flags_out | F_Z;
        if (q.bit_sel == BIT_SIGN && t) o.flags_out = o.flags_out | F_S;
      end
      OP_RES: o.result_byte = v & ~(8'h01 << q.bit_sel);
      OP_SET: o.result_byte = v | (8'h01 << q.bit_sel);
      OP_BLKCMP: begin
        d = q.acc - v;
        hb = q.acc[3:0] < v[3:0];
        u = d - {7'b0, hb};
        o.flags_out = (q.flags_in & F_C) | F_N | (d & F_S);
        if (d == 8'h00) o.flags_out = o.flags_out | F_Z;
        if (hb) o.flags_out = o.flags_out | F_H;
        if (q.remaining_count != 16'h0000) o.flags_out = o.flags_out | F_V;
        if (u[1]) o.flags_out = o.flags_out | F_X;
        if (u[3]) o.flags_out = o.flags_out | F_Y;
      end
      OP_BLKLD: begin
        o.flags_out = q.flags_in & (F_S | F_Z | F_C);
        if (q.remaining_count != 16'h0000) o.flags_out = o.flags_out | F_V;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return {4'($urandom), 12'hFFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic alu_req_t make_req(logic [4:0] op, logic [7:0] a, logic [7:0] fin,
                                        logic [7:0] opnd, logic [15:0] hl, logic [15:0] w,
                                        logic [2:0] sel, logic [15:0] bc);
    alu_req_t q;
    q.req_type = op;
    q.acc = a;
    q.flags_in = fin;
    q.operand8 = opnd;
    q.hl_in = hl;
    q.operand16 = w;
    q.bit_sel = sel;
    q.remaining_count = bc;
    return q;
  endfunction

  function automatic alu_req_t random_req();
    logic [4:0] op;
    logic [15:0] bc;
    if ($urandom_range(0, 19) == 0) op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else op = all_ops[$urandom_range(0, NUM_OPS - 1)];
    bc = ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom);
    return make_req(op, pick8(), 8'($urandom), pick8(), pick16(), pick16(),
                    3'($urandom), bc);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one transaction on the request side; called and returns at a rising edge
  task automatic send_req(alu_req_t item);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back('{req: item, rsp: alu_predict(item)});
    op_seen[item.req_type]++;
    items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(alu_rsp_t got);
    alu_expect_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected: %h", got));
      return;
    end
    e = pending_results.pop_front();
    results_checked++;
    if (got.result_byte !== e.rsp.result_byte)
      report_mismatch($sformatf("op %0d req %h result_byte %h exp %h", e.req.req_type,
                                e.req, got.result_byte, e.rsp.result_byte));
    if (got.result_pair !== e.rsp.result_pair)
      report_mismatch($sformatf("op %0d req %h result_pair %h exp %h", e.req.req_type,
                                e.req, got.result_pair, e.rsp.result_pair));
    if (got.flags_out !== e.rsp.flags_out)
      report_mismatch($sformatf("op %0d req %h flags_out %h exp %h", e.req.req_type,
                                e.req, got.flags_out, e.rsp.flags_out));
  endtask

  // response side: random stalls, one check per accepted transaction
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_result(rsp);
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("z80_alu_flag_unit_tb failed");
      $finish;
    end
  end

  task automatic test_all_ops();
    logic ones;
    for (int k = 0; k < NUM_OPS; k++) begin
      ones = k[0];
      send_req(make_req(all_ops[k], {8{ones}}, {8{ones}}, {8{ones}}, {16{ones}},
                        {16{ones}}, 3'(k), {16{ones}}));
    end
    send_req(make_req(OP_UNUSED_LO, 8'h5A, 8'hC3, 8'hFF, 16'h1234, 16'hFFFF, 3'd7, 16'h0001));
    send_req(make_req(OP_UNUSED_HI, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 3'd0, 16'h0000));
  endtask

  task automatic test_half_borrow();
    send_req(make_req(OP_SUB, 8'h10, 8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_SBC, 8'h10, F_C, 8'h00, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_CP, 8'h20, 8'h00, 8'h0F, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_SBC16, 8'h00, F_C, 8'h00, 16'h1000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_SBC16, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h0001, 3'd0, 16'h0000));
  endtask

  task automatic test_shift_pass();
    send_req(make_req(OP_SHIFT, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000, SH_PASS, 16'h0000));
    send_req(make_req(OP_SHIFT, 8'h00, F_C, 8'hA5, 16'h0000, 16'h0000, SH_PASS, 16'h0000));
    send_req(make_req(OP_BIT, 8'h00, 8'h00, 8'h80, 16'h0000, 16'h0000, BIT_SIGN, 16'h0000));
  endtask

  task automatic test_block_flags();
    send_req(make_req(OP_BLKLD, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_BLKLD, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 16'h8000));
    send_req(make_req(OP_BLKCMP, 8'h3C, 8'h00, 8'h3C, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    send_req(make_req(OP_BLKCMP, 8'h30, 8'hFF, 8'h0F, 16'h0000, 16'h0000, 3'd0, 16'hFFFF));
  endtask

  task automatic test_random_traffic(int n);
    src_gap_max = 5;
    sink_stall_max = 5;
    repeat (n) send_req(random_req());
  endtask

  task automatic test_back_to_back(int n);
    src_gap_max = 0;
    sink_stall_max = 0;
    repeat (n) send_req(random_req());
    src_gap_max = 5;
    sink_stall_max = 5;
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    repeat (8) begin
      repeat ($urandom_range(10, 40)) send_req(random_req());
      wait_drained();
      @(posedge clk);
    end
  endtask

  initial begin
    int codes_hit;
    int unused_sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_all_ops();
    test_half_borrow();
    test_shift_pass();
    test_block_flags();
    test_random_traffic(1200);
    test_back_to_back(200);
    test_drain_pause();
    test_random_traffic(200);

    wait_drained();
    repeat (10) @(posedge clk);

    codes_hit = 0;
    unused_sent = 0;
    for (int k = 0; k < 32; k++) begin
      if (k < NUM_OPS && op_seen[k] > 0) codes_hit++;
      if (k >= NUM_OPS) unused_sent += op_seen[k];
    end
    $display("summary: %0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("summary: %0d of %0d operation codes exercised, %0d with unused codes",
             codes_hit, NUM_OPS, unused_sent);
    if (mismatches == 0) begin
      $display("z80_alu_flag_unit_tb passed");
    end else begin
      $display("z80_alu_flag_unit_tb failed");
    end
    $finish;
  end

endmodule
